@@ hdl/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
// holds the transfer structs, the slot struct, the cell command struct and the codes
// no dependencies
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 6;
  localparam int TAG_BITS    = 8;
  localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                func;
    logic [KEY_BITS-1:0] entry_key;
    logic [TAG_BITS-1:0] entry_tag;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [OCC_BITS-1:0] occupancy;
    logic                is_empty;
  } spq_out_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } spq_slot_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                do_insert;
    logic                do_extract;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } spq_cmd_t;

endpackage

@@ hdl/spq_cell.sv @@
// one slot of the sorted priority queue cell row
// compares the broadcast key with its own and shifts toward its neighbors
// depends on spq_pkg
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  spq_cmd_t            cmd,
  input  logic [OCC_BITS-1:0] count,
  input  logic                left_disp,
  input  spq_slot_t           left_slot,
  input  spq_slot_t           right_slot,
  output logic                disp,
  output spq_slot_t           slot
);

  spq_slot_t slot_r;
  spq_slot_t slot_nxt;
  logic      valid;

  // slot holds an entry when its position is below the count
  assign valid = count > OCC_BITS'(IDX);

  // new entry goes ahead of this slot when the slot is free or holds a lower key
  assign disp = !valid || (slot_r.key < cmd.key);

  // insert: take the left neighbor or the new entry; extract: take the right neighbor
  always_comb begin
    slot_nxt = slot_r;
    if (cmd.do_insert && disp) begin
      if (left_disp) begin
        slot_nxt = left_slot;
      end else begin
        slot_nxt.key = cmd.key;
        slot_nxt.tag = cmd.tag;
      end
    end else if (cmd.do_extract) begin
      slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

@@ hdl/sorted_priority_queue_top.sv @@
// top level of the sorted priority queue: entry count, cell row and result register
// depends on spq_pkg and spq_cell
//
// A bounded priority queue of QUEUE_DEPTH entries kept in descending key order in a row of
// cells, one entry per cell. Every cell compares the incoming key with its own and shifts in
// the same cycle, so an operation is taken in every clock cycle (busy stays low) and its
// result appears on out_data with out_valid high in the cycle after the transfer. The
// receiver cannot stall the block: each result is present for a single cycle only. Equal
// keys leave in arrival order; insert into a full queue reports full and drops the entry,
// extract from an empty queue reports empty.
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_data,
  output logic     out_valid,
  output spq_out_t out_data
);

  logic [OCC_BITS-1:0] count_r;
  logic [OCC_BITS-1:0] count_nxt;
  logic                out_valid_r;
  spq_out_t            out_data_r;
  spq_out_t            out_data_nxt;
  logic                accept;
  logic                is_full;
  logic                is_none;
  spq_cmd_t            cmd;
  logic                disp  [QUEUE_DEPTH];
  spq_slot_t           slots [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_full = count_r == OCC_BITS'(QUEUE_DEPTH);
  assign is_none = count_r == '0;

  // command broadcast to the cells
  always_comb begin
    cmd.do_insert  = accept && (in_data.func == FUNC_INSERT) && !is_full;
    cmd.do_extract = accept && (in_data.func == FUNC_EXTRACT) && !is_none;
    cmd.key        = in_data.entry_key;
    cmd.tag        = in_data.entry_tag;
  end

  // cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic      l_disp;
    spq_slot_t l_slot;
    spq_slot_t r_slot;

    if (i == 0) begin : g_head
      assign l_disp = 1'b0;
      assign l_slot = '0;
    end else begin : g_body
      assign l_disp = disp[i-1];
      assign l_slot = slots[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_slot = '0;
    end else begin : g_inner
      assign r_slot = slots[i+1];
    end

    spq_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .left_disp  (l_disp),
      .left_slot  (l_slot),
      .right_slot (r_slot),
      .disp       (disp[i]),
      .slot       (slots[i])
    );
  end

  // entry count and result
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_extract) begin
      count_nxt = count_r - 1'b1;
    end

    out_data_nxt           = '0;
    out_data_nxt.status    = STATUS_OK;
    if (in_data.func == FUNC_INSERT) begin
      if (is_full) begin
        out_data_nxt.status = STATUS_FULL;
      end
    end else if (is_none) begin
      out_data_nxt.status = STATUS_EMPTY;
    end else begin
      out_data_nxt.out_key = slots[0].key;
      out_data_nxt.out_tag = slots[0].tag;
    end
    out_data_nxt.occupancy = count_nxt;
    out_data_nxt.is_empty  = count_nxt == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count stays within the cell row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= OCC_BITS'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // every transfer gives exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result after transfer");

  // full insert is dropped and leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.func == FUNC_INSERT) && is_full
    |=> (out_data.status == STATUS_FULL) && $stable(count_r))
    else $error("insert into full queue not dropped");

  // successful extract removes one entry
  a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_extract |=> count_r == $past(count_r) - 1'b1)
    else $error("extract did not remove one entry");

  // reported occupancy matches the count
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.occupancy == count_r) && (out_data.is_empty == (count_r == '0)))
    else $error("reported occupancy disagrees with entry count");

endmodule

@@ tb/sorted_priority_queue_top_test.sv @@
// self-checking testbench for sorted_priority_queue_top: directed table, then random bursts
// of inserts and extracts checked against a behavioral mirror of the sorted queue
// depends on spq_pkg and the sorted_priority_queue_top rtl
module sorted_priority_queue_top_test
  import spq_pkg::*;
();

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int NUM_ROWS     = 24;

  // one row of the directed table; pinned rows carry a hand-written result
  typedef struct packed {
    logic     pinned;
    spq_in_t  op;
    spq_out_t res;
  } row_t;

  localparam spq_out_t NO_RES = '0;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_data = '0;
  logic     out_valid;
  spq_out_t out_data;

  // travels with in_data so the monitor knows a pinned result at the transfer
  logic     pin_valid = 1'b0;
  spq_out_t pin_res = '0;

  // mirror of the queue contents, head at index 0
  logic [KEY_BITS-1:0] mirror_keys [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] mirror_tags [QUEUE_DEPTH];
  int                  mirror_count = 0;

  spq_out_t pending_results [$];

  int err_count     = 0;
  int cycle_count   = 0;
  int insert_count  = 0;
  int extract_count = 0;
  int full_drops    = 0;
  int empty_reads   = 0;
  int checked_count = 0;
  int peak_count    = 0;

  // directed table: empty extract, key/tag extremes, ties, fill to full, full drop
  row_t directed_rows [NUM_ROWS] = '{
    '{1'b1, '{FUNC_EXTRACT, 6'd0,  8'd0},   '{STATUS_EMPTY, 6'd0,  8'd0,   5'd0,  1'b1}},
    '{1'b1, '{FUNC_INSERT,  6'd0,  8'd0},   '{STATUS_OK,    6'd0,  8'd0,   5'd1,  1'b0}},
    '{1'b1, '{FUNC_EXTRACT, 6'd0,  8'd0},   '{STATUS_OK,    6'd0,  8'd0,   5'd0,  1'b1}},
    '{1'b1, '{FUNC_INSERT,  6'd63, 8'd255}, '{STATUS_OK,    6'd0,  8'd0,   5'd1,  1'b0}},
    '{1'b1, '{FUNC_EXTRACT, 6'd63, 8'd255}, '{STATUS_OK,    6'd63, 8'd255, 5'd0,  1'b1}},
    '{1'b0, '{FUNC_INSERT,  6'd5,  8'd1},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd63, 8'd2},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd5,  8'd3},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd0,  8'd4},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd63, 8'd5},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd31, 8'd6},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd32, 8'd7},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd5,  8'd8},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd0,  8'd9},   NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd62, 8'd10},  NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd1,  8'd11},  NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd63, 8'd12},  NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd31, 8'd13},  NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd7,  8'd14},  NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd5,  8'd15},  NO_RES},
    '{1'b0, '{FUNC_INSERT,  6'd0,  8'd16},  NO_RES},
    '{1'b1, '{FUNC_INSERT,  6'd63, 8'd255}, '{STATUS_FULL,  6'd0,  8'd0,   5'd16, 1'b0}},
    '{1'b0, '{FUNC_EXTRACT, 6'd63, 8'd255}, NO_RES},
    '{1'b0, '{FUNC_EXTRACT, 6'd0,  8'd0},   NO_RES}
  };

  sorted_priority_queue_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one operation to the mirror and return the result it should produce
  function automatic spq_out_t mirror_apply(spq_in_t op);
    spq_out_t r;
    int       pos;
    int       i;
    r = '0;
    r.status = STATUS_OK;
    if (op.func == FUNC_INSERT) begin
      if (mirror_count >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // new entry goes behind every entry with a greater or equal key
        pos = 0;
        while (pos < mirror_count && mirror_keys[pos] >= op.entry_key) pos++;
        for (i = mirror_count; i > pos; i--) begin
          mirror_keys[i] = mirror_keys[i-1];
          mirror_tags[i] = mirror_tags[i-1];
        end
        mirror_keys[pos] = op.entry_key;
        mirror_tags[pos] = op.entry_tag;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      // pop the head and close the gap
      r.out_key = mirror_keys[0];
      r.out_tag = mirror_tags[0];
      for (i = 1; i < mirror_count; i++) begin
        mirror_keys[i-1] = mirror_keys[i];
        mirror_tags[i-1] = mirror_tags[i];
      end
      mirror_count--;
    end
    r.occupancy = OCC_BITS'(mirror_count);
    r.is_empty  = (mirror_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, field, got, want);
    err_count++;
  endtask

  task automatic check_field(string field, int got, int want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  // monitor: check results against the oldest expectation, then record new transfers
  always @(posedge clk) begin
    spq_out_t want;
    spq_out_t predicted;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_data.status), -1);
        end else begin
          want = pending_results.pop_front();
          check_field("status",    int'(out_data.status),    int'(want.status));
          check_field("out_key",   int'(out_data.out_key),   int'(want.out_key));
          check_field("out_tag",   int'(out_data.out_tag),   int'(want.out_tag));
          check_field("occupancy", int'(out_data.occupancy), int'(want.occupancy));
          check_field("is_empty",  int'(out_data.is_empty),  int'(want.is_empty));
          checked_count++;
        end
      end
      if (start && !busy) begin
        predicted = mirror_apply(in_data);
        // append the expectation at the tail of the queue
        pending_results = {pending_results, (pin_valid ? pin_res : predicted)};
        if (in_data.func == FUNC_INSERT) insert_count++;
        else extract_count++;
        if (predicted.status == STATUS_FULL) full_drops++;
        if (predicted.status == STATUS_EMPTY) empty_reads++;
        if (mirror_count > peak_count) peak_count = mirror_count;
      end
    end
  end

  // hold one operation until its transfer; start stays high for a following item
  task automatic send_op(spq_in_t op, logic pinned, spq_out_t res);
    in_data   <= op;
    start     <= 1'b1;
    pin_valid <= pinned;
    pin_res   <= res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random operation; tight keys crowd around one value to force ties
  function automatic spq_in_t random_op(int insert_pct, bit tight, logic [KEY_BITS-1:0] base);
    spq_in_t op;
    op.func      = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
    op.entry_key = tight ? (base ^ KEY_BITS'($urandom_range(1))) : KEY_BITS'($urandom_range(63));
    op.entry_tag = TAG_BITS'($urandom_range(255));
    return op;
  endfunction

  // stimulus
  initial begin
    int                  sent;
    int                  burst_len;
    int                  insert_pct;
    bit                  tight;
    bit                  paused;
    logic [KEY_BITS-1:0] tie_base;

    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_op(directed_rows[r].op, directed_rows[r].pinned, directed_rows[r].res);
      if ($urandom_range(3) == 0) idle_cycles($urandom_range(1, 3));
    end

    // random bursts; each burst leans toward filling or draining the queue, or keeps an even mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 24);
      case ($urandom_range(2))
        0: insert_pct = 20;
        1: insert_pct = 50;
        default: insert_pct = 80;
      endcase
      tight    = ($urandom_range(2) == 0);
      tie_base = KEY_BITS'($urandom_range(63));
      repeat (burst_len) begin
        send_op(random_op(insert_pct, tight, tie_base), 1'b0, NO_RES);
        sent++;
      end
      // some bursts run straight into the next one
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 6));
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    // wind down
    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d inserts (%0d dropped as full) and %0d extracts (%0d on empty)",
             insert_count, full_drops, extract_count, empty_reads);
    $display("%0d results checked, queue reached %0d of %0d entries",
             checked_count, peak_count, QUEUE_DEPTH);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
